FILE: design/brl_pkg.sv
// Shared types, constants and register indexes of the line rasterizer.
`timescale 1ns / 1ps

package brl_pkg;

  localparam int COORD_BITS   = 12;
  localparam int CFG_BITS     = 12;
  localparam int CFG_ADDR_BITS = 2;
  localparam int ERR_BITS     = COORD_BITS + 2;
  localparam int COUNT_BITS   = COORD_BITS + 1;

  localparam logic [CFG_BITS-1:0] RASTER_RESET = CFG_BITS'(800);

  localparam logic [CFG_ADDR_BITS-1:0] CFG_RASTER_WIDTH  = CFG_ADDR_BITS'(0);
  localparam logic [CFG_ADDR_BITS-1:0] CFG_RASTER_HEIGHT = CFG_ADDR_BITS'(1);

  localparam logic MODE_LOAD = 1'b0;
  localparam logic MODE_STEP = 1'b1;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic [COORD_BITS-1:0]        delta_t;
  typedef logic signed [ERR_BITS-1:0]   err_t;
  typedef logic [COUNT_BITS-1:0]        count_t;

  typedef struct packed {
    logic   mode;
    coord_t start_x;
    coord_t start_y;
    coord_t end_x;
    coord_t end_y;
  } in_item_t;

  typedef struct packed {
    coord_t pixel_x;
    coord_t pixel_y;
    logic   on_screen;
    logic   last_pixel;
  } out_item_t;

  // Walk state prepared from a load beat.
  typedef struct packed {
    logic   major_is_x;
    logic   major_step_down;
    coord_t cur_major;
    coord_t cur_minor;
    delta_t delta_major;
    delta_t delta_minor;
    err_t   error_term;
    count_t pixels_left;
  } line_setup_t;

endpackage

FILE: design/bresenham_line_rasterizer.sv
// Top level of the Bresenham line rasterizer: line state, pixel stepping, clip and output.
// A step beat's pixel is registered into the result register, or parked in the skid stage while the output stalls.
// Throughput: one beat per cycle while in_ready is high; each step is a single update of the error and
// coordinate registers, and a load beat gives no result.
// The skid stage behind the result register takes one result during a stall; in_ready drops only while it is full.
// Reset (synchronous, rst_n low) drops any loaded line, empties the output and sets 800 x 800.
`timescale 1ns / 1ps

module bresenham_line_rasterizer (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  brl_pkg::in_item_t                   in_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output brl_pkg::out_item_t                  out_data,
  input  logic                                cfg_we,
  input  logic [brl_pkg::CFG_ADDR_BITS-1:0]   cfg_addr,
  input  logic [brl_pkg::CFG_BITS-1:0]        cfg_wdata
);
  import brl_pkg::*;

  logic [CFG_BITS-1:0] raster_width_r;
  logic [CFG_BITS-1:0] raster_height_r;

  logic        active_r;
  logic        active_nxt;
  line_setup_t line_r;
  line_setup_t line_nxt;
  line_setup_t setup;

  logic        buf_full;
  logic        in_fire;
  logic        emit;
  out_item_t   pixel;
  coord_t      px;
  coord_t      py;
  err_t        err_adj;

  brl_setup u_setup (
    .item  (in_data),
    .setup (setup)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      raster_width_r  <= RASTER_RESET;
      raster_height_r <= RASTER_RESET;
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_RASTER_WIDTH:  raster_width_r  <= cfg_wdata;
        CFG_RASTER_HEIGHT: raster_height_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign in_ready = !buf_full;
  assign in_fire  = in_valid && in_ready;
  assign emit     = in_fire && (in_data.mode == MODE_STEP) && active_r &&
                    (line_r.pixels_left != '0);

  always_comb begin
    px = line_r.major_is_x ? line_r.cur_major : line_r.cur_minor;
    py = line_r.major_is_x ? line_r.cur_minor : line_r.cur_major;
    pixel.pixel_x    = px;
    pixel.pixel_y    = py;
    pixel.on_screen  = !px[COORD_BITS-1] && !py[COORD_BITS-1] &&
                       ($unsigned(px) < raster_width_r) && ($unsigned(py) < raster_height_r);
    pixel.last_pixel = (line_r.pixels_left == COUNT_BITS'(1));
  end

  always_comb begin
    line_nxt   = line_r;
    active_nxt = active_r;
    err_adj    = line_r.error_term;
    if (in_fire && (in_data.mode == MODE_LOAD)) begin
      line_nxt   = setup;
      active_nxt = 1'b1;
    end else if (emit) begin
      if (!line_r.error_term[ERR_BITS-1]) begin
        line_nxt.cur_minor = line_r.cur_minor + COORD_BITS'(1);
        err_adj = line_r.error_term - $signed({2'b00, line_r.delta_major});
      end
      line_nxt.error_term  = err_adj + $signed({2'b00, line_r.delta_minor});
      line_nxt.cur_major   = line_r.major_step_down ? line_r.cur_major - COORD_BITS'(1)
                                                    : line_r.cur_major + COORD_BITS'(1);
      line_nxt.pixels_left = line_r.pixels_left - COUNT_BITS'(1);
      if (line_r.pixels_left == COUNT_BITS'(1)) begin
        active_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      line_r   <= '0;
    end else begin
      active_r <= active_nxt;
      line_r   <= line_nxt;
    end
  end

  brl_out_buf u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (emit),
    .push_data (pixel),
    .full      (buf_full),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

`ifndef SYNTHESIS
  a_active_has_pixels: assert property (@(posedge clk) disable iff (!rst_n)
    active_r |-> (line_r.pixels_left != '0))
    else $error("active line with no pixels left");

  a_last_ends_line: assert property (@(posedge clk) disable iff (!rst_n)
    (emit && pixel.last_pixel) |=> !active_r)
    else $error("line still active after its last pixel");

  a_load_starts_line: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && (in_data.mode == MODE_LOAD)) |=> active_r)
    else $error("load beat did not start a line");

  a_stall_means_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid)
    else $error("input stalled while the output is empty");
`endif

endmodule

FILE: design/brl_setup.sv
// Line setup: deltas, major axis, start point and initial error from two endpoints.
`timescale 1ns / 1ps

module brl_setup (
  input  brl_pkg::in_item_t    item,
  output brl_pkg::line_setup_t setup
);
  import brl_pkg::*;

  logic signed [COORD_BITS:0] diff_x;
  logic signed [COORD_BITS:0] diff_y;
  logic [COORD_BITS:0]        neg_x;
  logic [COORD_BITS:0]        neg_y;
  delta_t                     dx;
  delta_t                     dy;
  logic                       major_x;
  coord_t                     a_maj;
  coord_t                     a_min;
  coord_t                     b_maj;
  coord_t                     b_min;
  logic                       swap;
  coord_t                     s_maj;
  coord_t                     e_maj;
  delta_t                     d_maj;
  delta_t                     d_min;

  always_comb begin
    diff_x = {item.end_x[COORD_BITS-1], item.end_x} - {item.start_x[COORD_BITS-1], item.start_x};
    diff_y = {item.end_y[COORD_BITS-1], item.end_y} - {item.start_y[COORD_BITS-1], item.start_y};
    neg_x  = -diff_x;
    neg_y  = -diff_y;
    // The magnitude of a difference of two coordinates always fits in COORD_BITS unsigned.
    dx = diff_x[COORD_BITS] ? neg_x[COORD_BITS-1:0] : diff_x[COORD_BITS-1:0];
    dy = diff_y[COORD_BITS] ? neg_y[COORD_BITS-1:0] : diff_y[COORD_BITS-1:0];
    major_x = (dx >= dy);

    if (major_x) begin
      a_maj = item.start_x;
      a_min = item.start_y;
      b_maj = item.end_x;
      b_min = item.end_y;
      d_maj = dx;
      d_min = dy;
    end else begin
      a_maj = item.start_y;
      a_min = item.start_x;
      b_maj = item.end_y;
      b_min = item.end_x;
      d_maj = dy;
      d_min = dx;
    end

    // Start from the smaller minor coordinate; on a tie, from the smaller major one.
    swap  = (b_min < a_min) || ((b_min == a_min) && (b_maj < a_maj));
    s_maj = swap ? b_maj : a_maj;
    e_maj = swap ? a_maj : b_maj;

    setup.major_is_x      = major_x;
    setup.major_step_down = (e_maj < s_maj);
    setup.cur_major       = s_maj;
    setup.cur_minor       = swap ? b_min : a_min;
    setup.delta_major     = d_maj;
    setup.delta_minor     = d_min;
    setup.error_term      = $signed({2'b00, d_min}) - $signed({2'b00, d_maj});
    setup.pixels_left     = {1'b0, d_maj} + COUNT_BITS'(1);
  end

endmodule

FILE: design/brl_out_buf.sv
// Result register with a skid stage that takes one more result during an output stall before full is raised.
`timescale 1ns / 1ps

module brl_out_buf (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  brl_pkg::out_item_t push_data,
  output logic               full,
  output logic               out_valid,
  input  logic               out_ready,
  output brl_pkg::out_item_t out_data
);
  import brl_pkg::*;

  logic      out_valid_r;
  logic      out_valid_nxt;
  out_item_t out_data_r;
  out_item_t out_data_nxt;
  logic      skid_valid_r;
  logic      skid_valid_nxt;
  out_item_t skid_data_r;
  out_item_t skid_data_nxt;

  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_data_nxt   = out_data_r;
    skid_valid_nxt = skid_valid_r;
    skid_data_nxt  = skid_data_r;
    if (out_valid_r && !out_ready) begin
      // Output is stalled: a new result parks in the skid stage, which the top level only pushes into while empty.
      if (push) begin
        skid_valid_nxt = 1'b1;
        skid_data_nxt  = push_data;
      end
    end else if (skid_valid_r) begin
      out_valid_nxt  = 1'b1;
      out_data_nxt   = skid_data_r;
      skid_valid_nxt = push;
      skid_data_nxt  = push_data;
    end else begin
      out_valid_nxt = push;
      out_data_nxt  = push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
    out_data_r  <= out_data_nxt;
    skid_data_r <= skid_data_nxt;
  end

  assign full      = skid_valid_r;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
